[sv/layered_noise_flicker_generator_defines.svh]
// ----------------------------------------------------------------------------
// Flicker generator assertion macros
// Concurrent assertion wrappers for the flicker generator RTL.
// ----------------------------------------------------------------------------
`ifndef LAYERED_NOISE_FLICKER_GENERATOR_DEFINES_SVH
`define LAYERED_NOISE_FLICKER_GENERATOR_DEFINES_SVH

`ifndef SYNTH
// Checked only while out of reset.
`define FLK_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("flicker assertion failed");
// Checked at every edge, reset included.
`define FLK_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("flicker assertion failed");
`else
`define FLK_ASSERT(lbl, prop)
`define FLK_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

[sv/flk_pkg.sv]
// ----------------------------------------------------------------------------
// Flicker generator package
// Constants, tables and types shared by the flicker generator modules.
// ----------------------------------------------------------------------------
package flk_pkg;

  localparam int unsigned MAX_LAYERS = 8;
  localparam int unsigned CFG_IDX_W  = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_LEVEL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_STEP   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_STEP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_JITTER_STEP = 3'd4;

  localparam logic [15:0] BASE_RESET   = 16'd22938;
  localparam logic [15:0] DEFAULT_STEP = 16'd50;
  localparam logic [15:0] STEP_RESET [4] = '{16'd900, 16'd180, 16'd65, 16'd35};

  localparam logic [31:0] HASH_C1 = 32'h27d4eb2d;
  localparam logic [31:0] HASH_C2 = 32'h85ebca6b;

  localparam logic [31:0] LAYER_SALT [MAX_LAYERS] =
    '{32'h11, 32'h22, 32'h33, 32'h44, 32'h0, 32'h0, 32'h0, 32'h0};
  localparam logic signed [15:0] LAYER_GAIN [MAX_LAYERS] =
    '{16'sd16384, 16'sd19661, 16'sd11796, 16'sd6554, 16'sd0, 16'sd0, 16'sd0, 16'sd0};

  // Divider: {time_ms, 16'b0} / step, 4 quotient bits per stage.
  localparam int unsigned DQ_W       = 48;
  localparam int unsigned REM_W      = 17;
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STAGES = DQ_W / DIV_BITS;

  localparam int unsigned LAYER_STAGES = 5;
  // Valid bits for divider, layer math and the accumulate stage.
  localparam int unsigned VLD_N = DIV_STAGES + LAYER_STAGES + 1;

  localparam int unsigned PROD_W = 32;
  localparam int unsigned ACC_W  = 36;

  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

endpackage

[sv/flk_in_if.sv]
// ----------------------------------------------------------------------------
// Flicker input channel
// Valid/ready channel carrying one millisecond timestamp per transaction.
// ----------------------------------------------------------------------------
interface flk_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_ms;

  modport source (output valid, output time_ms, input ready);
  modport sink (input valid, input time_ms, output ready);
endinterface

[sv/flk_out_if.sv]
// ----------------------------------------------------------------------------
// Flicker result channel
// Valid/ready channel carrying one brightness sample per transaction.
// ----------------------------------------------------------------------------
interface flk_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] brightness;
  logic        clipped;

  modport source (output valid, output brightness, output clipped, input ready);
  modport sink (input valid, input brightness, input clipped, output ready);
endinterface

[sv/flk_div.sv]
// ----------------------------------------------------------------------------
// Flicker pipelined divider
// Restoring division of {time_ms, 16'b0} by the cell period, giving the cell
// index in the upper quotient bits and the Q0.16 fraction in the lower ones.
// ----------------------------------------------------------------------------
module flk_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] ms,
  input  logic [15:0] step,
  output logic [31:0] idx,
  output logic [15:0] frac
);
  import flk_pkg::*;

  logic [DQ_W-1:0]  dq_r  [DIV_STAGES];
  logic [REM_W-1:0] rem_r [DIV_STAGES-1];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_st
    logic [REM_W-1:0] rem_in;
    logic [REM_W-1:0] rem_nxt;
    logic [DQ_W-1:0]  dq_in;
    logic [DQ_W-1:0]  dq_nxt;

    if (g == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = {ms, 16'b0};
    end else begin : g_next
      assign rem_in = rem_r[g-1];
      assign dq_in  = dq_r[g-1];
    end

    always_comb begin
      rem_nxt = rem_in;
      dq_nxt  = dq_in;
      for (int b = 0; b < DIV_BITS; b++) begin
        rem_nxt = {rem_nxt[REM_W-2:0], dq_nxt[DQ_W-1]};
        dq_nxt  = {dq_nxt[DQ_W-2:0], 1'b0};
        if (rem_nxt >= {1'b0, step}) begin
          rem_nxt   = rem_nxt - {1'b0, step};
          dq_nxt[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dq_r[g] <= dq_nxt;
      end
    end

    if (g < DIV_STAGES - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g] <= rem_nxt;
        end
      end
    end
  end

  assign idx  = dq_r[DIV_STAGES-1][DQ_W-1:16];
  assign frac = dq_r[DIV_STAGES-1][15:0];

endmodule

[sv/flk_layer.sv]
// ----------------------------------------------------------------------------
// Flicker noise layer
// One value-noise layer: divider, hash of both cell ends, smoothstep ease,
// interpolation, and the centered, gain-scaled contribution.
// ----------------------------------------------------------------------------
module flk_layer #(
  parameter int unsigned LAYER = 0
) (
  input  logic          clk,
  input  logic          en,
  input  logic [31:0]   ms,
  input  logic [15:0]   step_cfg,
  output flk_pkg::prod_t prod
);
  import flk_pkg::*;

  localparam logic [31:0]        SALT = LAYER_SALT[LAYER];
  localparam logic signed [15:0] GAIN = LAYER_GAIN[LAYER];

  logic [15:0] step_eff;
  logic [31:0] idx;
  logic [15:0] frac;

  // A zero period register selects the default period.
  assign step_eff = (step_cfg == 16'd0) ? DEFAULT_STEP : step_cfg;

  flk_div u_div (
    .clk  (clk),
    .en   (en),
    .ms   (ms),
    .step (step_eff),
    .idx  (idx),
    .frac (frac)
  );

  // Stage A: first hash multiply, fraction squared.
  logic [31:0] va_nxt, vb_nxt;
  logic [31:0] va_r, vb_r, pa_r, pb_r;
  logic [31:0] tsq;
  logic [15:0] t_r, t2_r;

  assign va_nxt = idx ^ SALT;
  assign vb_nxt = (idx + 32'd1) ^ SALT;
  assign tsq    = frac * frac;

  always_ff @(posedge clk) begin
    if (en) begin
      va_r <= va_nxt;
      vb_r <= vb_nxt;
      pa_r <= va_nxt * HASH_C1;
      pb_r <= vb_nxt * HASH_C1;
      t_r  <= frac;
      t2_r <= tsq[31:16];
    end
  end

  // Stage B: xor-shift and second hash multiply, smoothstep weight.
  logic [31:0] ha, hb, xa, xb;
  logic [17:0] ease_k;
  logic [33:0] s_full;
  logic [31:0] ma_r, mb_r;
  logic [15:0] s_r;

  assign ha     = va_r ^ pa_r;
  assign hb     = vb_r ^ pb_r;
  assign xa     = ha ^ (ha >> 15);
  assign xb     = hb ^ (hb >> 15);
  assign ease_k = 18'd196608 - {1'b0, t_r, 1'b0};
  assign s_full = t2_r * ease_k;

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r <= xa * HASH_C2;
      mb_r <= xb * HASH_C2;
      s_r  <= s_full[31:16];
    end
  end

  // Stage C: final xor-shift, take bits 23..8, weight both ends.
  logic [31:0] za, zb;
  logic [15:0] fa, fb;
  logic [16:0] w_a;
  logic [32:0] la_r;
  logic [31:0] lb_r;

  assign za  = ma_r ^ (ma_r >> 13);
  assign zb  = mb_r ^ (mb_r >> 13);
  assign fa  = za[23:8];
  assign fb  = zb[23:8];
  assign w_a = 17'h10000 - {1'b0, s_r};

  always_ff @(posedge clk) begin
    if (en) begin
      la_r <= fa * w_a;
      lb_r <= fb * s_r;
    end
  end

  // Stage D: interpolated value.
  logic [33:0] lsum;
  logic [15:0] n_r;

  assign lsum = {1'b0, la_r} + {2'b0, lb_r};

  always_ff @(posedge clk) begin
    if (en) begin
      n_r <= lsum[31:16];
    end
  end

  // Stage E: center on one half and scale. n - 32768 is n with its MSB flipped.
  logic signed [15:0] cen;
  prod_t              prod_r;

  assign cen = $signed({~n_r[15], n_r[14:0]});

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= cen * GAIN;
    end
  end

  assign prod = prod_r;

endmodule

[sv/layered_noise_flicker_generator.sv]
// ----------------------------------------------------------------------------
// Layered value-noise flicker generator
// Turns a millisecond timestamp into a clamped candle brightness sample.
// ----------------------------------------------------------------------------
// Usage: send a timestamp on in_ch; one brightness sample and a clamp flag
// come back on out_ch for every input transaction, in order.
// The transaction passes 19 register stages, and the first one captures it
// at the accepting edge: 12 divider stages (four quotient bits each), 5 noise
// stages per layer, one stage summing the layers and one output register.
// One transaction per cycle unless out_ch stalls; all layers run in parallel.
// Configuration writes on cfg_we/cfg_idx/cfg_wdata take effect at once and
// belong to the idle periods between bursts of timestamps.
// Reset loads the default base level and periods and empties the pipeline.
// When the receiver holds out_ch.ready low with a result waiting, the whole
// pipeline holds in place and in_ch.ready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "layered_noise_flicker_generator_defines.svh"

module layered_noise_flicker_generator #(
  parameter int unsigned NUM_LAYERS = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  flk_in_if.sink                          in_ch,
  flk_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [flk_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [15:0]                     cfg_wdata
);
  import flk_pkg::*;

  logic [15:0] base_r;
  logic [15:0] step_r [4];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
      for (int i = 0; i < 4; i++) begin
        step_r[i] <= STEP_RESET[i];
      end
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BASE_LEVEL:  base_r    <= cfg_wdata;
        CFG_SLOW_STEP:   step_r[0] <= cfg_wdata;
        CFG_MID_STEP:    step_r[1] <= cfg_wdata;
        CFG_FAST_STEP:   step_r[2] <= cfg_wdata;
        CFG_JITTER_STEP: step_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  logic adv;
  logic out_valid_r;

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = adv;

  logic [VLD_N-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[VLD_N-2:0], in_ch.valid};
      out_valid_r <= vld_r[VLD_N-1];
    end
  end

  prod_t prod [NUM_LAYERS];

  for (genvar k = 0; k < NUM_LAYERS; k++) begin : g_layer
    logic [15:0] lstep;
    // Layers past the fourth have no register and run at the default period.
    if (k < 4) begin : g_cfg
      assign lstep = step_r[k];
    end else begin : g_def
      assign lstep = 16'd0;
    end

    flk_layer #(.LAYER(k)) u_layer (
      .clk      (clk),
      .en       (adv),
      .ms       (in_ch.time_ms),
      .step_cfg (lstep),
      .prod     (prod[k])
    );
  end

  acc_t acc_nxt;
  acc_t acc_r;

  always_comb begin
    acc_nxt = $signed({{(ACC_W-32){1'b0}}, base_r, 16'b0});
    for (int i = 0; i < NUM_LAYERS; i++) begin
      acc_nxt = acc_nxt + {{(ACC_W-PROD_W){prod[i][PROD_W-1]}}, prod[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_r <= acc_nxt;
    end
  end

  logic [15:0] bright_nxt, bright_r;
  logic        clip_nxt, clip_r;

  always_comb begin
    if (acc_r[ACC_W-1]) begin
      bright_nxt = 16'd0;
      clip_nxt   = 1'b1;
    end else if (acc_r[ACC_W-2:32] != '0) begin
      bright_nxt = 16'hffff;
      clip_nxt   = 1'b1;
    end else begin
      bright_nxt = acc_r[31:16];
      clip_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bright_r <= bright_nxt;
      clip_r   <= clip_nxt;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.brightness = bright_r;
  assign out_ch.clipped    = clip_r;

  `FLK_ASSERT_ALWAYS(a_reset_empties, !rst_n |=> !out_valid_r)
  `FLK_ASSERT(a_stall_holds_valids, !adv |=> $stable(vld_r))
  `FLK_ASSERT(a_last_stage_reaches_out, (vld_r[VLD_N-1] && adv) |=> out_valid_r)
  `FLK_ASSERT(a_clip_only_at_rails, (out_valid_r && bright_r != 16'd0 && bright_r != 16'hffff) |-> !clip_r)

endmodule
